// ===== sv/bsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Types, constants and saturating helpers shared by the barometric
// compensation datapath.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int DATA_W        = 64;
   localparam int RAW_SAMPLE_W  = 20;
   localparam int RAW_WIDTH_DEF = 20;
   localparam int FRAC          = 24;
   localparam int SHIFT_W       = 6;
   localparam int MUL_STEPS     = 64;
   localparam int DIV_STEPS     = 128;
   localparam int CSR_INDEX_W   = 2;
   localparam int REQ_DATA_W    = 24;
   localparam int RSP_DATA_W    = 48;

   localparam logic [CSR_INDEX_W-1:0] REG_TEMP_CAL       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_CAL_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_CAL_HIGH = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PRESS_CAL_NINE = 2'd3;

   localparam logic OP_TEMPERATURE = 1'b0;
   localparam logic OP_PRESSURE    = 1'b1;

   typedef logic signed [DATA_W-1:0] word_type;

   localparam word_type WORD_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam word_type WORD_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic               start;
      logic [SHIFT_W-1:0] sh;
   } mul_req_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_ISSUE,
      ST_MUL_WAIT,
      ST_DIV_ISSUE,
      ST_DIV_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      SP_SQ, SP_P6, SP_P5, SP_B4, SP_P3, SP_P2, SP_C19, SP_C15, SP_P1,
      SP_B12, SP_N, SP_PP, SP_P9, SP_P8, SP_S4,
      SP_TD2, SP_TDD, SP_T3, SP_T20, SP_T34, SP_T5
   } step_type;

   function automatic logic [DATA_W-1:0] mag_of(input word_type x);
      mag_of = x[DATA_W-1] ? (DATA_W'(0) - DATA_W'(x)) : DATA_W'(x);
   endfunction

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic signed [DATA_W:0] s;
      s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
      if (s[DATA_W] != s[DATA_W-1]) begin
         sat_add = s[DATA_W] ? WORD_MIN : WORD_MAX;
      end else begin
         sat_add = s[DATA_W-1:0];
      end
   endfunction

   function automatic word_type pack_sat(input logic neg, input logic [DATA_W-1:0] hi,
                                         input logic [DATA_W-1:0] lo);
      logic [DATA_W-1:0] lim;
      logic [DATA_W-1:0] m;
      lim = neg ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      m = ((hi != '0) || (lo > lim)) ? lim : lo;
      pack_sat = neg ? word_type'(DATA_W'(0) - m) : word_type'(m);
   endfunction

endpackage

// ===== sv/barometric_sensor_compensation.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Temperature and pressure compensation of raw barometer readings.
//
// The req channel takes one raw sample per transaction, tagged by tuser as
// temperature or pressure. The rsp channel returns one result per
// transaction. The csr channel writes the calibration registers and is
// always ready; it is to be used only while the block is idle, which the
// block itself does not enforce. A sequencer drives one shared shift-add
// multiplier and, for pressure, one bit-serial divider. A temperature item
// takes 6 products; a pressure item takes 15 products and one division,
// or stops after 9 products when the divisor is zero. One item is in work
// at a time and req_tready is low meanwhile, so no new item is taken
// until the last one is done.
// The result register decouples the sides: a new item is accepted while a
// result waits, and a finished item waits in its last state while the
// receiver stalls. Reset clears the calibration registers, the stored
// fine temperature and all handshake state.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation #(
   parameter int RAW_WIDTH = bsc_pkg::RAW_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // raw_sample [19:0], zero padding above
   input  logic [bsc_pkg::REQ_DATA_W-1:0]      req_tdata,
   // opcode [0]
   input  logic [0:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // temperature_centi [15:0], pressure_q8 [40:16], zero_divisor [41], zeros above
   output logic [bsc_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // result_kind [0]
   output logic [0:0]                          rsp_tuser,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bsc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [bsc_pkg::DATA_W-1:0]          csr_data
);

   localparam int RW      = bsc_pkg::RAW_SAMPLE_W;
   localparam int LOW_CUT = RW - RAW_WIDTH;
   localparam logic [RW-1:0] RAW_MASK = ~((RW'(1) << LOW_CUT) - RW'(1));

   function automatic bsc_pkg::word_type sx16(input logic [15:0] v);
      sx16 = bsc_pkg::word_type'($signed(v));
   endfunction

   bsc_pkg::state_type state_ff, state_in;
   bsc_pkg::step_type  step_ff, step_in;

   logic [47:0]       temp_cal_ff;
   logic [63:0]       pcl_ff;
   logic [63:0]       pch_ff;
   logic [15:0]       p9_ff;
   logic [31:0]       fine_ff, fine_in;

   bsc_pkg::word_type ra_ff, ra_in, rsq_ff, rsq_in, rb_ff, rb_in, rc_ff, rc_in;
   bsc_pkg::word_type rn_ff, rn_in, rp_ff, rp_in, rt_ff, rt_in;
   logic [RW-1:0]     raw_ff, raw_in;
   logic              kind_ff, kind_in;
   logic              zflag_ff, zflag_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bsc_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                           rsp_kind_ff, rsp_kind_in;

   bsc_pkg::mul_req_type        mul_req;
   logic                        mul_start;
   logic [bsc_pkg::SHIFT_W-1:0] mul_sh;
   bsc_pkg::word_type           op_a, op_b, mul_res, div_res;
   logic                        mul_done, div_done, div_start;

   bsc_pkg::word_type sx, sy, wb, d_val, n0;
   logic [63:0]       tmag, pround;
   logic [15:0]       centi;
   logic [24:0]       pq8;
   logic              load_rsp;

   assign mul_req = {mul_start, mul_sh};

   bsc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .req    (mul_req),
      .op_a   (op_a),
      .op_b   (op_b),
      .done   (mul_done),
      .result (mul_res)
   );

   bsc_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (rn_ff),
      .den    (rc_ff),
      .done   (div_done),
      .result (div_res)
   );

   always_comb begin
      d_val = $signed({44'd0, raw_ff}) - $signed({44'd0, temp_cal_ff[15:0], 4'd0});
      n0    = ((64'sd1 <<< 20) - $signed({44'd0, raw_ff})) <<< bsc_pkg::FRAC;
      op_a  = rt_ff;
      op_b  = 64'sd1;
      mul_sh = '0;
      sx = mul_res;
      sy = '0;
      case (step_ff)
         bsc_pkg::SP_SQ: begin
            op_a = ra_ff; op_b = ra_ff; mul_sh = 6'd24;
         end
         bsc_pkg::SP_P6: begin
            op_a = rsq_ff; op_b = sx16(pch_ff[31:16]); mul_sh = 6'd15;
         end
         bsc_pkg::SP_P5: begin
            op_a = ra_ff; op_b = sx16(pch_ff[15:0]) <<< 1; sx = rt_ff; sy = mul_res;
         end
         bsc_pkg::SP_B4: begin
            op_a = rb_ff; mul_sh = 6'd2; sy = sx16(pcl_ff[63:48]) <<< 40;
         end
         bsc_pkg::SP_P3: begin
            op_a = rsq_ff; op_b = sx16(pcl_ff[47:32]); mul_sh = 6'd19;
         end
         bsc_pkg::SP_P2: begin
            op_a = ra_ff; op_b = sx16(pcl_ff[31:16]); sx = rt_ff; sy = mul_res;
         end
         bsc_pkg::SP_C19: begin
            op_a = rc_ff; mul_sh = 6'd19;
         end
         bsc_pkg::SP_C15: begin
            op_a = rc_ff; mul_sh = 6'd15; sy = 64'sd1 <<< bsc_pkg::FRAC;
         end
         bsc_pkg::SP_P1: begin
            op_a = rc_ff; op_b = $signed({48'd0, pcl_ff[15:0]});
         end
         bsc_pkg::SP_B12: begin
            op_a = rb_ff; mul_sh = 6'd12; sx = n0; sy = -mul_res;
         end
         bsc_pkg::SP_N: begin
            op_a = rn_ff; op_b = 64'sd6250;
         end
         bsc_pkg::SP_PP: begin
            op_a = rp_ff; op_b = rp_ff; mul_sh = 6'd24;
         end
         bsc_pkg::SP_P9: begin
            op_a = rt_ff; op_b = sx16(p9_ff); mul_sh = 6'd31;
         end
         bsc_pkg::SP_P8: begin
            op_a = rp_ff; op_b = sx16(pch_ff[63:48]); mul_sh = 6'd15;
            sx = rt_ff; sy = mul_res;
         end
         bsc_pkg::SP_S4: begin
            op_a = bsc_pkg::sat_add(rt_ff, sx16(pch_ff[47:32]) <<< bsc_pkg::FRAC);
            mul_sh = 6'd4; sx = rp_ff; sy = mul_res;
         end
         bsc_pkg::SP_TD2: begin
            op_a = d_val; op_b = sx16(temp_cal_ff[31:16]);
         end
         bsc_pkg::SP_TDD: begin
            op_a = d_val; op_b = d_val;
         end
         bsc_pkg::SP_T3: begin
            op_a = rc_ff; op_b = sx16(temp_cal_ff[47:32]);
         end
         bsc_pkg::SP_T20: begin
            op_a = rt_ff; op_b = 64'sd1 <<< 20; sy = rc_ff;
         end
         bsc_pkg::SP_T34: begin
            op_a = rt_ff; mul_sh = 6'd34;
         end
         bsc_pkg::SP_T5: begin
            op_a = rt_ff; op_b = 64'sd5;
         end
         default: begin
            op_a = rt_ff;
         end
      endcase
      wb = bsc_pkg::sat_add(sx, sy);
   end

   always_comb begin
      tmag = (bsc_pkg::mag_of(rt_ff) + 64'd128) >> 8;
      if (rt_ff[63]) begin
         centi = (tmag > 64'd32768) ? 16'h8000 : 16'(64'd0 - tmag);
      end else begin
         centi = (tmag > 64'd32767) ? 16'h7FFF : tmag[15:0];
      end
      pround = (64'(rp_ff) + 64'h8000) >> 16;
      if (zflag_ff || (rp_ff <= 0)) begin
         pq8 = '0;
      end else begin
         pq8 = (pround > 64'h1FF_FFFF) ? 25'h1FF_FFFF : pround[24:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      fine_in       = fine_ff;
      ra_in         = ra_ff;
      rsq_in        = rsq_ff;
      rb_in         = rb_ff;
      rc_in         = rc_ff;
      rn_in         = rn_ff;
      rp_in         = rp_ff;
      rt_in         = rt_ff;
      raw_in        = raw_ff;
      kind_in       = kind_ff;
      zflag_in      = zflag_ff;
      mul_start     = 1'b0;
      div_start     = 1'b0;
      load_rsp      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_kind_in   = rsp_kind_ff;
      case (state_ff)
         bsc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               raw_in   = req_tdata[RW-1:0] & RAW_MASK;
               kind_in  = req_tuser[0];
               zflag_in = 1'b0;
               ra_in    = ($signed({{32{fine_ff[31]}}, fine_ff}) <<< 23)
                          - (64'sd64000 <<< bsc_pkg::FRAC);
               step_in  = (req_tuser[0] == bsc_pkg::OP_PRESSURE) ?
                          bsc_pkg::SP_SQ : bsc_pkg::SP_TD2;
               state_in = bsc_pkg::ST_MUL_ISSUE;
            end
         end
         bsc_pkg::ST_MUL_ISSUE: begin
            mul_start = 1'b1;
            state_in  = bsc_pkg::ST_MUL_WAIT;
         end
         bsc_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = bsc_pkg::ST_MUL_ISSUE;
               case (step_ff)
                  bsc_pkg::SP_SQ:  begin rsq_in = wb; step_in = bsc_pkg::SP_P6;  end
                  bsc_pkg::SP_P6:  begin rt_in  = wb; step_in = bsc_pkg::SP_P5;  end
                  bsc_pkg::SP_P5:  begin rb_in  = wb; step_in = bsc_pkg::SP_B4;  end
                  bsc_pkg::SP_B4:  begin rb_in  = wb; step_in = bsc_pkg::SP_P3;  end
                  bsc_pkg::SP_P3:  begin rt_in  = wb; step_in = bsc_pkg::SP_P2;  end
                  bsc_pkg::SP_P2:  begin rc_in  = wb; step_in = bsc_pkg::SP_C19; end
                  bsc_pkg::SP_C19: begin rc_in  = wb; step_in = bsc_pkg::SP_C15; end
                  bsc_pkg::SP_C15: begin rc_in  = wb; step_in = bsc_pkg::SP_P1;  end
                  bsc_pkg::SP_P1: begin
                     rc_in   = wb;
                     step_in = bsc_pkg::SP_B12;
                     if (wb == 0) begin
                        zflag_in = 1'b1;
                        state_in = bsc_pkg::ST_DONE;
                     end
                  end
                  bsc_pkg::SP_B12: begin rn_in = wb; step_in = bsc_pkg::SP_N; end
                  bsc_pkg::SP_N: begin
                     rn_in    = wb;
                     step_in  = bsc_pkg::SP_PP;
                     state_in = bsc_pkg::ST_DIV_ISSUE;
                  end
                  bsc_pkg::SP_PP:  begin rt_in = wb; step_in = bsc_pkg::SP_P9; end
                  bsc_pkg::SP_P9:  begin rt_in = wb; step_in = bsc_pkg::SP_P8; end
                  bsc_pkg::SP_P8:  begin rt_in = wb; step_in = bsc_pkg::SP_S4; end
                  bsc_pkg::SP_S4: begin
                     rp_in    = wb;
                     state_in = bsc_pkg::ST_DONE;
                  end
                  bsc_pkg::SP_TD2: begin rt_in = wb; step_in = bsc_pkg::SP_TDD; end
                  bsc_pkg::SP_TDD: begin rc_in = wb; step_in = bsc_pkg::SP_T3;  end
                  bsc_pkg::SP_T3:  begin rc_in = wb; step_in = bsc_pkg::SP_T20; end
                  bsc_pkg::SP_T20: begin rt_in = wb; step_in = bsc_pkg::SP_T34; end
                  bsc_pkg::SP_T34: begin
                     rt_in   = wb;
                     fine_in = wb[31:0];
                     step_in = bsc_pkg::SP_T5;
                  end
                  bsc_pkg::SP_T5: begin
                     rt_in    = wb;
                     state_in = bsc_pkg::ST_DONE;
                  end
                  default: begin
                     state_in = bsc_pkg::ST_IDLE;
                  end
               endcase
            end
         end
         bsc_pkg::ST_DIV_ISSUE: begin
            div_start = 1'b1;
            state_in  = bsc_pkg::ST_DIV_WAIT;
         end
         bsc_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               rp_in    = div_res;
               state_in = bsc_pkg::ST_MUL_ISSUE;
            end
         end
         bsc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = kind_ff;
               if (kind_ff == bsc_pkg::OP_PRESSURE) begin
                  rsp_data_in = {6'd0, zflag_ff, pq8, 16'd0};
               end else begin
                  rsp_data_in = {32'd0, centi};
               end
               state_in = bsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bsc_pkg::ST_IDLE;
         step_ff      <= bsc_pkg::SP_SQ;
         fine_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         temp_cal_ff  <= '0;
         pcl_ff       <= '0;
         pch_ff       <= '0;
         p9_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         fine_ff      <= fine_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            case (csr_index)
               bsc_pkg::REG_TEMP_CAL:       temp_cal_ff <= csr_data[47:0];
               bsc_pkg::REG_PRESS_CAL_LOW:  pcl_ff      <= csr_data;
               bsc_pkg::REG_PRESS_CAL_HIGH: pch_ff      <= csr_data;
               bsc_pkg::REG_PRESS_CAL_NINE: p9_ff       <= csr_data[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      ra_ff       <= ra_in;
      rsq_ff      <= rsq_in;
      rb_ff       <= rb_in;
      rc_ff       <= rc_in;
      rn_ff       <= rn_in;
      rp_ff       <= rp_in;
      rt_ff       <= rt_in;
      raw_ff      <= raw_in;
      kind_ff     <= kind_in;
      zflag_ff    <= zflag_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
   end

   assign req_tready = (state_ff == bsc_pkg::ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("block ready again right after taking a transaction");

   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == bsc_pkg::ST_MUL_WAIT))
      else $error("multiplier finished outside a wait state");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten while a result waits");

   a_temp_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[41:16] == 26'd0))
      else $error("temperature result carries pressure fields");

   a_zero_div_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[41]) |-> (rsp_tuser[0] && rsp_tdata[40:0] == 41'd0))
      else $error("zero divisor result carries data");

endmodule

// ===== sv/bsc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_mul
// Shared shift-add multiplier: signed 64 x 64 product, scaled down by a
// power of two with truncation toward zero and saturated to 64 bits.
// ----------------------------------------------------------------------------
module bsc_mul (
   input  logic                clock,
   input  logic                reset,
   input  bsc_pkg::mul_req_type req,
   input  bsc_pkg::word_type   op_a,
   input  bsc_pkg::word_type   op_b,
   output logic                done,
   output bsc_pkg::word_type   result
);

   localparam int CNT_W = $clog2(bsc_pkg::MUL_STEPS + 1);
   localparam int W     = bsc_pkg::DATA_W;

   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [W-1:0]                x_ff, x_in;
   logic [W-1:0]                y_ff, y_in;
   logic [W-1:0]                hi_ff, hi_in;
   logic [W-1:0]                lo_ff, lo_in;
   logic                        neg_ff, neg_in;
   logic [bsc_pkg::SHIFT_W-1:0] sh_ff, sh_in;
   bsc_pkg::word_type           res_ff, res_in;

   logic [W:0]     sum;
   logic [2*W-1:0] shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      neg_in  = neg_ff;
      sh_in   = sh_ff;
      res_in  = res_ff;
      sum     = {1'b0, hi_ff} + (y_ff[0] ? {1'b0, x_ff} : '0);
      shifted = {hi_ff, lo_ff} >> sh_ff;
      if (!busy_ff) begin
         if (req.start) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            x_in    = bsc_pkg::mag_of(op_a);
            y_in    = bsc_pkg::mag_of(op_b);
            neg_in  = op_a[W-1] ^ op_b[W-1];
            sh_in   = req.sh;
            hi_in   = '0;
            lo_in   = '0;
         end
      end else if (cnt_ff != CNT_W'(bsc_pkg::MUL_STEPS)) begin
         hi_in  = sum[W:1];
         lo_in  = {sum[0], lo_ff[W-1:1]};
         y_in   = y_ff >> 1;
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         res_in  = bsc_pkg::pack_sat(neg_ff, shifted[2*W-1:W], shifted[W-1:0]);
         done_in = 1'b1;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff   <= x_in;
      y_ff   <= y_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      neg_ff <= neg_in;
      sh_ff  <= sh_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule

// ===== sv/bsc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_div
// Restoring long divider: trunc(num * 2^24 / den) over a 128-bit dividend,
// one quotient bit per cycle, saturated to 64 bits.
// ----------------------------------------------------------------------------
module bsc_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  bsc_pkg::word_type num,
   input  bsc_pkg::word_type den,
   output logic              done,
   output bsc_pkg::word_type result
);

   localparam int CNT_W = $clog2(bsc_pkg::DIV_STEPS + 1);
   localparam int W     = bsc_pkg::DATA_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [2*W-1:0]    work_ff, work_in;
   logic [W-1:0]      rem_ff, rem_in;
   logic [W-1:0]      d_ff, d_in;
   logic              neg_ff, neg_in;
   bsc_pkg::word_type res_ff, res_in;

   logic [W:0] r2;
   logic [W:0] diff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      r2      = {rem_ff, work_ff[2*W-1]};
      diff    = r2 - {1'b0, d_ff};
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            cnt_in  = '0;
            work_in = (2*W)'(bsc_pkg::mag_of(num)) << bsc_pkg::FRAC;
            rem_in  = '0;
            d_in    = bsc_pkg::mag_of(den);
            neg_in  = num[W-1] ^ den[W-1];
         end
      end else if (cnt_ff != CNT_W'(bsc_pkg::DIV_STEPS)) begin
         if (r2 >= {1'b0, d_ff}) begin
            rem_in  = diff[W-1:0];
            work_in = {work_ff[2*W-2:0], 1'b1};
         end else begin
            rem_in  = r2[W-1:0];
            work_in = {work_ff[2*W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + CNT_W'(1);
      end else begin
         res_in  = bsc_pkg::pack_sat(neg_ff, work_ff[2*W-1:W], work_ff[W-1:0]);
         done_in = 1'b1;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      d_ff    <= d_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

endmodule
